// ===== hw/rtl/bmsrfp_pkg.sv =====
// Shared types and constants for the battery-monitor reply frame parser.
// No dependencies; imported by the parser, emitter and top-level modules of the block.
`timescale 1ns / 1ps
`default_nettype none
package bmsrfp_pkg;

    localparam int MAX_CELLS   = 16;
    localparam int BASIC_WORDS = 4;
    localparam int RAM_DEPTH   = (MAX_CELLS > BASIC_WORDS) ? MAX_CELLS : BASIC_WORDS;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int CNT_W       = $clog2(RAM_DEPTH + 1);

    localparam logic [7:0] SOF_BYTE      = 8'hDD;
    localparam logic [7:0] EOF_BYTE      = 8'h77;
    localparam logic [7:0] REG_CELLS     = 8'h04;
    localparam logic [7:0] REG_BASIC     = 8'h03;
    localparam logic [7:0] BASIC_MIN_LEN = 8'd27;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_REG,
        PH_STATUS,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHK_HI,
        PH_CHK_LO,
        PH_STOP
    } parse_phase_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_START,
        EM_READ,
        EM_LOAD
    } emit_state_t;

    typedef enum logic [1:0] {
        KIND_BASIC = 2'd0,
        KIND_CELL  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_CHECKSUM = 3'd1,
        ERR_STOP     = 3'd2,
        ERR_REGISTER = 3'd3,
        ERR_SHORT    = 3'd4,
        ERR_TIMEOUT  = 3'd5
    } err_code_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [15:0]       data;
    } ram_wr_t;

    typedef struct packed {
        logic             valid;
        kind_t            kind;
        err_code_t        err;
        logic [CNT_W-1:0] count;
    } frame_job_t;

    typedef struct packed {
        kind_t       kind;
        err_code_t   error_code;
        logic [3:0]  cell_index;
        logic [4:0]  cell_count;
        logic [15:0] cell_millivolts;
        logic [15:0] pack_voltage;
        logic [15:0] pack_current;
        logic [15:0] remaining_charge;
        logic [15:0] nominal_charge;
        logic        last;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bmsrfp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module bmsrfp_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bmsrfp_parse.sv =====
// Byte-level frame parser: start hunt, header, payload, checksum and stop check.
// Writes payload words into the word store and hands finished frames to the emitter.
// Depends on bmsrfp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bmsrfp_parse
    import bmsrfp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic       cmd,
    input  wire logic [7:0] rx_byte,
    output ram_wr_t         ram_wr,
    output frame_job_t      job
);

    parse_phase_t phase_reg, phase_next;
    logic [7:0]   reg_code_reg, reg_code_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   pos_reg, pos_next;
    logic [15:0]  sum_reg, sum_next;
    logic [15:0]  chk_reg, chk_next;
    logic [7:0]   hold_reg, hold_next;

    logic [6:0]       half_len;
    logic [6:0]       word_idx;
    logic [CNT_W-1:0] cell_cnt;
    logic [15:0]      expected;

    assign half_len = len_reg[7:1];
    assign word_idx = pos_reg[7:1];
    assign cell_cnt = (half_len > 7'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(half_len);
    assign expected = ~sum_reg + 16'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        reg_code_next = reg_code_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        chk_next      = chk_reg;
        hold_next     = hold_reg;
        ram_wr        = '0;
        job           = '0;

        if (accept)
        begin
            if (cmd)
            begin
                if (phase_reg != PH_HUNT)
                begin
                    phase_next = PH_HUNT;
                    job.valid  = 1'b1;
                    job.kind   = KIND_ERROR;
                    job.err    = ERR_TIMEOUT;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (rx_byte == SOF_BYTE)
                        begin
                            phase_next = PH_REG;
                        end
                    end
                    PH_REG:
                    begin
                        reg_code_next = rx_byte;
                        sum_next      = '0;
                        phase_next    = PH_STATUS;
                    end
                    PH_STATUS:
                    begin
                        sum_next   = sum_reg + {8'h00, rx_byte};
                        phase_next = PH_LEN;
                    end
                    PH_LEN:
                    begin
                        sum_next   = sum_reg + {8'h00, rx_byte};
                        len_next   = rx_byte;
                        pos_next   = '0;
                        phase_next = (rx_byte == 8'h00) ? PH_CHK_HI : PH_PAYLOAD;
                    end
                    PH_PAYLOAD:
                    begin
                        sum_next = sum_reg + {8'h00, rx_byte};
                        if (!pos_reg[0])
                        begin
                            hold_next = rx_byte;
                        end
                        else
                        begin
                            ram_wr.addr = RAM_AW'(word_idx);
                            ram_wr.data = {hold_reg, rx_byte};
                            ram_wr.en   = ((reg_code_reg == REG_CELLS)
                                           && (word_idx < 7'(MAX_CELLS)))
                                       || ((reg_code_reg == REG_BASIC)
                                           && (word_idx < 7'(BASIC_WORDS)));
                        end
                        pos_next = pos_reg + 8'd1;
                        if (({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg})
                        begin
                            phase_next = PH_CHK_HI;
                        end
                    end
                    PH_CHK_HI:
                    begin
                        chk_next   = {rx_byte, 8'h00};
                        phase_next = PH_CHK_LO;
                    end
                    PH_CHK_LO:
                    begin
                        chk_next   = {chk_reg[15:8], rx_byte};
                        phase_next = PH_STOP;
                    end
                    PH_STOP:
                    begin
                        phase_next = PH_HUNT;
                        job.valid  = 1'b1;
                        job.kind   = KIND_ERROR;
                        priority if (expected != chk_reg)
                        begin
                            job.err = ERR_CHECKSUM;
                        end
                        else if (rx_byte != EOF_BYTE)
                        begin
                            job.err = ERR_STOP;
                        end
                        else if (reg_code_reg == REG_CELLS)
                        begin
                            job.kind  = KIND_CELL;
                            job.count = cell_cnt;
                            job.valid = (cell_cnt != '0);
                        end
                        else if (reg_code_reg == REG_BASIC)
                        begin
                            if (len_reg < BASIC_MIN_LEN)
                            begin
                                job.err = ERR_SHORT;
                            end
                            else
                            begin
                                job.kind = KIND_BASIC;
                            end
                        end
                        else
                        begin
                            job.err = ERR_REGISTER;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            reg_code_reg <= '0;
            len_reg      <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            chk_reg      <= '0;
            hold_reg     <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            reg_code_reg <= reg_code_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            chk_reg      <= chk_next;
            hold_reg     <= hold_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bmsrfp_emit.sv =====
// Result sequencer: reads stored words back and drives the registered output item.
// Depends on bmsrfp_pkg; read port of bmsrfp_ram.
`timescale 1ns / 1ps
`default_nettype none
module bmsrfp_emit
    import bmsrfp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  frame_job_t             job,
    output logic                   idle,
    output logic                   rd_en,
    output logic [RAM_AW-1:0]      rd_addr,
    input  wire logic [15:0]       rd_data,
    output result_t                result,
    output logic                   result_valid,
    input  wire logic              result_ready
);

    emit_state_t      state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    kind_t            kind_reg, kind_next;
    err_code_t        err_reg, err_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic out_free;
    logic cell_last;

    assign out_free     = !out_valid_reg || result_ready;
    assign cell_last    = (idx_reg == (count_reg - CNT_W'(1)));
    assign idle         = (state_reg == EM_IDLE);
    assign result       = out_reg;
    assign result_valid = out_valid_reg;
    assign rd_addr      = idx_reg[RAM_AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        err_next       = err_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        rd_en          = 1'b0;

        unique case (state_reg)
            EM_IDLE:
            begin
                if (job.valid)
                begin
                    kind_next  = job.kind;
                    err_next   = job.err;
                    count_next = job.count;
                    state_next = EM_START;
                end
            end
            EM_START:
            begin
                idx_next = '0;
                if (kind_reg == KIND_ERROR)
                begin
                    if (out_free)
                    begin
                        out_next            = '0;
                        out_next.kind       = KIND_ERROR;
                        out_next.error_code = err_reg;
                        out_next.last       = 1'b1;
                        out_valid_next      = 1'b1;
                        state_next          = EM_IDLE;
                    end
                end
                else
                begin
                    state_next = EM_READ;
                end
            end
            EM_READ:
            begin
                rd_en      = 1'b1;
                state_next = EM_LOAD;
            end
            EM_LOAD:
            begin
                if (out_free)
                begin
                    if (kind_reg == KIND_CELL)
                    begin
                        out_next                 = '0;
                        out_next.kind            = KIND_CELL;
                        out_next.cell_index      = 4'(idx_reg);
                        out_next.cell_count      = 5'(count_reg);
                        out_next.cell_millivolts = rd_data;
                        out_next.last            = cell_last;
                        out_valid_next           = 1'b1;
                        idx_next                 = idx_reg + CNT_W'(1);
                        state_next               = cell_last ? EM_IDLE : EM_READ;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = EM_READ;
                        priority if (idx_reg == CNT_W'(0))
                        begin
                            out_next              = '0;
                            out_next.kind         = KIND_BASIC;
                            out_next.pack_voltage = rd_data;
                        end
                        else if (idx_reg == CNT_W'(1))
                        begin
                            out_next.pack_current = rd_data;
                        end
                        else if (idx_reg == CNT_W'(2))
                        begin
                            out_next.remaining_charge = rd_data;
                        end
                        else
                        begin
                            out_next.nominal_charge = rd_data;
                            out_next.last           = 1'b1;
                            out_valid_next          = 1'b1;
                            state_next              = EM_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            idx_reg       <= '0;
            kind_reg      <= KIND_BASIC;
            err_reg       <= ERR_NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            err_reg       <= err_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/bms_response_frame_parser_core.sv =====
// Reply frame parser top level: one received byte or timeout per input item, one per cycle
// while the input is not stalled. A stop byte or timeout that yields a result stalls the input
// while results go out: an error item is loaded in the start state, basic info after four
// word reads, cells one item per word read; output back-pressure lengthens the stall.
// Asynchronous active-low reset returns to start-byte hunt; the word store is not cleared.
// Depends on bmsrfp_pkg, bmsrfp_parse, bmsrfp_emit, bmsrfp_ram.
`timescale 1ns / 1ps
`default_nettype none
module bms_response_frame_parser_core
    import bmsrfp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    input  wire logic        s_axis_tuser,   // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,   // error_code, cell_index, cell_count,
                                             // cell_millivolts, pack_voltage,
                                             // pack_current, remaining_charge,
                                             // nominal_charge, zero pad
    output logic [1:0]       m_axis_tuser,   // kind
    output logic             m_axis_tlast
);

    ram_wr_t           ram_wr;
    frame_job_t        job;
    logic              emit_idle;
    logic              rd_en;
    logic [RAM_AW-1:0] rd_addr;
    logic [15:0]       rd_data;
    result_t           res;
    logic              accept;

    assign s_axis_tready = emit_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;

    bmsrfp_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (s_axis_tuser),
        .rx_byte (s_axis_tdata),
        .ram_wr  (ram_wr),
        .job     (job)
    );

    bmsrfp_ram #(
        .DEPTH (RAM_DEPTH),
        .WIDTH (16),
        .AW    (RAM_AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bmsrfp_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job),
        .idle         (emit_idle),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .result       (res),
        .result_valid (m_axis_tvalid),
        .result_ready (m_axis_tready)
    );

    assign m_axis_tdata = {4'b0000, res.nominal_charge, res.remaining_charge,
                           res.pack_current, res.pack_voltage, res.cell_millivolts,
                           res.cell_count, res.cell_index, res.error_code};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking bench for bms_response_frame_parser_core: byte streams of reply frames go
// in, a scoreboard class predicts each cell, basic-info and error result and checks them.
// Depends on bmsrfp_pkg and the core RTL only.
`timescale 1ns / 1ps
module testbench
    import bmsrfp_pkg::*;
;
    localparam int CYCLE_LIMIT = 400000;

    class reply_frame_scoreboard;
        parse_phase_t phase;
        logic [7:0]   reg_code;
        logic [7:0]   plen;
        logic [7:0]   ppos;
        logic [7:0]   hold;
        logic [15:0]  sum;
        logic [15:0]  chk;
        logic [15:0]  cells [MAX_CELLS];
        logic [15:0]  basic [BASIC_WORDS];
        result_t      expected_readings [$];
        int           produced;
        int           checked;
        int           mismatches;

        function new();
            phase = PH_HUNT;
            reg_code = '0;
            plen = '0;
            ppos = '0;
            hold = '0;
            sum = '0;
            chk = '0;
            produced = 0;
            checked = 0;
            mismatches = 0;
        endfunction

        function void queue_error(err_code_t code);
            result_t r;
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = code;
            r.last = 1'b1;
            expected_readings.push_back(r);
            produced++;
        endfunction

        function void close_frame(logic [7:0] stop);
            result_t r;
            int count;
            if (16'h0 - sum != chk)
                queue_error(ERR_CHECKSUM);
            else if (stop != EOF_BYTE)
                queue_error(ERR_STOP);
            else if (reg_code == REG_CELLS)
            begin
                count = plen >> 1;
                if (count > MAX_CELLS)
                    count = MAX_CELLS;
                for (int i = 0; i < count; i++)
                begin
                    r = '0;
                    r.kind = KIND_CELL;
                    r.cell_index = 4'(i);
                    r.cell_count = 5'(count);
                    r.cell_millivolts = cells[i];
                    r.last = (i == count - 1);
                    expected_readings.push_back(r);
                    produced++;
                end
            end
            else if (reg_code == REG_BASIC)
            begin
                if (plen < BASIC_MIN_LEN)
                    queue_error(ERR_SHORT);
                else
                begin
                    r = '0;
                    r.kind = KIND_BASIC;
                    r.pack_voltage = basic[0];
                    r.pack_current = basic[1];
                    r.remaining_charge = basic[2];
                    r.nominal_charge = basic[3];
                    r.last = 1'b1;
                    expected_readings.push_back(r);
                    produced++;
                end
            end
            else
                queue_error(ERR_REGISTER);
        endfunction

        function void take_item(logic cmd, logic [7:0] b);
            int idx;
            if (cmd)
            begin
                if (phase != PH_HUNT)
                begin
                    phase = PH_HUNT;
                    queue_error(ERR_TIMEOUT);
                end
                return;
            end
            case (phase)
                PH_HUNT:
                    if (b == SOF_BYTE)
                        phase = PH_REG;
                PH_REG:
                begin
                    reg_code = b;
                    sum = '0;
                    phase = PH_STATUS;
                end
                PH_STATUS:
                begin
                    sum += 16'(b);
                    phase = PH_LEN;
                end
                PH_LEN:
                begin
                    sum += 16'(b);
                    plen = b;
                    ppos = '0;
                    phase = (b == 8'd0) ? PH_CHK_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    sum += 16'(b);
                    if (!ppos[0])
                        hold = b;
                    else
                    begin
                        idx = ppos >> 1;
                        if (reg_code == REG_CELLS && idx < MAX_CELLS)
                            cells[idx] = {hold, b};
                        if (reg_code == REG_BASIC && idx < BASIC_WORDS)
                            basic[idx] = {hold, b};
                    end
                    if (int'(ppos) + 1 >= int'(plen))
                        phase = PH_CHK_HI;
                    ppos = ppos + 8'd1;
                end
                PH_CHK_HI:
                begin
                    chk = {b, 8'h00};
                    phase = PH_CHK_LO;
                end
                PH_CHK_LO:
                begin
                    chk[7:0] = b;
                    phase = PH_STOP;
                end
                default:
                begin
                    phase = PH_HUNT;
                    close_frame(b);
                end
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
            end
        endfunction

        function void check_reading(logic [95:0] data, logic [1:0] user, logic last);
            result_t want;
            if (expected_readings.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected result, expected none, got kind %h data %h",
                         $time, user, data);
                return;
            end
            want = expected_readings.pop_front();
            checked++;
            check_field("kind", 16'(want.kind), 16'(user));
            check_field("error_code", 16'(want.error_code), 16'(data[2:0]));
            check_field("cell_index", 16'(want.cell_index), 16'(data[6:3]));
            check_field("cell_count", 16'(want.cell_count), 16'(data[11:7]));
            check_field("cell_millivolts", want.cell_millivolts, data[27:12]);
            check_field("pack_voltage", want.pack_voltage, data[43:28]);
            check_field("pack_current", want.pack_current, data[59:44]);
            check_field("remaining_charge", want.remaining_charge, data[75:60]);
            check_field("nominal_charge", want.nominal_charge, data[91:76]);
            check_field("pad", 16'h0, 16'(data[95:92]));
            check_field("last", 16'(want.last), 16'(last));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    reply_frame_scoreboard tracker = new();
    logic [7:0] frame_body [$];
    bit         sender_steady = 1'b0;
    bit         long_hold_req = 1'b0;
    int         items_sent = 0;
    int         frames_sent = 0;
    int         cycle_count = 0;

    bms_response_frame_parser_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[bms_response_frame_parser_core] ERROR");
        $finish;
    end

    // result side: check accepted items, then pick the next ready level
    initial
    begin : reader
        int hold_left;
        int ready_run;
        int pick;
        hold_left = 0;
        ready_run = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                tracker.check_reading(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left = 400;
                ready_run = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (ready_run > 0)
            begin
                ready_run--;
                m_axis_tready <= 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    ready_run = $urandom_range(0, 30);
                    m_axis_tready <= 1'b1;
                end
                else
                begin
                    hold_left = (pick < 92) ? $urandom_range(0, 3) : $urandom_range(10, 40);
                    m_axis_tready <= 1'b0;
                end
            end
        end
    end

    task automatic send_item(input logic cmd, input logic [7:0] b);
        int gap;
        int pick;
        gap = 0;
        if (!sender_steady)
        begin
            pick = $urandom_range(0, 99);
            if (pick >= 95)
                gap = $urandom_range(8, 30);
            else if (pick >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        tracker.take_item(cmd, b);
        items_sent++;
    endtask

    task automatic append_random(input int n);
        repeat (n) frame_body.push_back(8'($urandom));
    endtask

    task automatic push_word(input logic [15:0] w);
        frame_body.push_back(w[15:8]);
        frame_body.push_back(w[7:0]);
    endtask

    // sends the frame around frame_body; cut_at >= 0 replaces that byte with a timeout and ends the frame there
    task automatic send_frame(input logic [7:0] reg_code, input logic [7:0] status,
                              input bit bad_sum, input bit bad_stop, input int cut_at);
        logic [7:0]  frame_bytes [$];
        logic [15:0] sum;
        logic [15:0] chk;
        logic [7:0]  stop;
        sum = 16'(status) + 16'(frame_body.size());
        foreach (frame_body[i])
            sum += 16'(frame_body[i]);
        chk = 16'h0 - sum;
        if (bad_sum)
            chk ^= 16'h1 << $urandom_range(0, 15);
        stop = bad_stop ? (EOF_BYTE ^ 8'($urandom_range(1, 255))) : EOF_BYTE;
        frame_bytes.push_back(SOF_BYTE);
        frame_bytes.push_back(reg_code);
        frame_bytes.push_back(status);
        frame_bytes.push_back(8'(frame_body.size()));
        foreach (frame_body[i])
            frame_bytes.push_back(frame_body[i]);
        frame_bytes.push_back(chk[15:8]);
        frame_bytes.push_back(chk[7:0]);
        frame_bytes.push_back(stop);
        frame_body.delete();
        frames_sent++;
        foreach (frame_bytes[i])
        begin
            if (i == cut_at)
            begin
                send_item(1'b1, 8'($urandom));
                return;
            end
            send_item(1'b0, frame_bytes[i]);
        end
    endtask

    initial
    begin : stimulus
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);

        // noise and a timeout while hunting
        sender_steady = 1'b1;
        send_item(1'b0, 8'h00);
        send_item(1'b0, EOF_BYTE);
        send_item(1'b1, 8'h5A);
        sender_steady = 1'b0;

        push_word(16'hFFFF);
        push_word(16'h0000);
        push_word(16'h8000);
        push_word(16'h7FFF);
        send_frame(REG_CELLS, 8'hFF, 1'b0, 1'b0, -1);
        // start byte inside a frame, odd length, no cells
        frame_body.push_back(SOF_BYTE);
        send_frame(REG_CELLS, SOF_BYTE, 1'b0, 1'b0, -1);
        send_frame(SOF_BYTE, SOF_BYTE, 1'b0, 1'b0, -1);
        send_frame(REG_BASIC, 8'h00, 1'b0, 1'b0, -1);
        send_frame(REG_CELLS, 8'h00, 1'b1, 1'b1, -1);
        send_frame(REG_CELLS, 8'h00, 1'b0, 1'b1, -1);
        append_random(4);
        send_frame(REG_BASIC, 8'h00, 1'b0, 1'b0, 6);

        // long receiver hold while a capped cell frame and a basic-info frame are offered
        long_hold_req = 1'b1;
        sender_steady = 1'b1;
        append_random(34);
        send_frame(REG_CELLS, 8'h00, 1'b0, 1'b0, -1);
        push_word(16'hFFFF);
        push_word(16'h8000);
        push_word(16'h0000);
        push_word(16'hFFFF);
        append_random(19);
        send_frame(REG_BASIC, 8'hA5, 1'b0, 1'b0, -1);
        sender_steady = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (tracker.expected_readings.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Sent %0d frames in %0d input items (noise, timeouts, bad sums and stops,",
                 frames_sent, items_sent);
        $display("a long output hold); checked %0d cell, basic-info and error results.",
                 tracker.checked);
        if (tracker.mismatches == 0 && tracker.expected_readings.size() == 0)
            $display("[bms_response_frame_parser_core] OK");
        else
            $display("[bms_response_frame_parser_core] ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bmsrfp_pkg.sv
hw/rtl/bmsrfp_ram.sv
hw/rtl/bmsrfp_parse.sv
hw/rtl/bmsrfp_emit.sv
hw/rtl/bms_response_frame_parser_core.sv
sim/testbench.sv
